### rtl/tidv_pkg.sv
`timescale 1ns / 1ps

package tidv_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   localparam logic KIND_CPF = 1'b0;
   localparam logic KIND_CNPJ = 1'b1;

   localparam logic [3:0] CpfLength = 4'd11;
   localparam logic [3:0] CnpjLength = 4'd14;
   localparam logic [3:0] CountMax = 4'd15;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_COUNT = 2'd1,
      STATUS_ALL_SAME  = 2'd2,
      STATUS_MISMATCH  = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0] digit;
      logic       is_digit;
      logic       first;
      logic       last;
      logic       kind;
   } entry_type;

   function automatic logic [3:0] weight_one(input logic kind, input logic [3:0] idx);
      logic [3:0] w;
      w = 4'd0;
      if (kind == KIND_CPF) begin
         if (idx < 4'd9) begin
            w = 4'd10 - idx;
         end
      end else begin
         case (idx)
            4'd0: w = 4'd5;
            4'd1: w = 4'd4;
            4'd2: w = 4'd3;
            4'd3: w = 4'd2;
            4'd4: w = 4'd9;
            4'd5: w = 4'd8;
            4'd6: w = 4'd7;
            4'd7: w = 4'd6;
            4'd8: w = 4'd5;
            4'd9: w = 4'd4;
            4'd10: w = 4'd3;
            4'd11: w = 4'd2;
            default: w = 4'd0;
         endcase
      end
      return w;
   endfunction

   function automatic logic [3:0] weight_two(input logic kind, input logic [3:0] idx);
      logic [3:0] w;
      w = 4'd0;
      if (kind == KIND_CPF) begin
         if (idx < 4'd10) begin
            w = 4'd11 - idx;
         end
      end else begin
         case (idx)
            4'd0: w = 4'd6;
            4'd1: w = 4'd5;
            4'd2: w = 4'd4;
            4'd3: w = 4'd3;
            4'd4: w = 4'd2;
            4'd5: w = 4'd9;
            4'd6: w = 4'd8;
            4'd7: w = 4'd7;
            4'd8: w = 4'd6;
            4'd9: w = 4'd5;
            4'd10: w = 4'd4;
            4'd11: w = 4'd3;
            4'd12: w = 4'd2;
            default: w = 4'd0;
         endcase
      end
      return w;
   endfunction

   // s mod 11 via reciprocal 186/2048; estimate is low by at most one
   function automatic logic [3:0] mod_eleven(input logic [9:0] s);
      logic [17:0] prod;
      logic [6:0]  q;
      logic [9:0]  r;
      prod = {8'd0, s} * 18'd186;
      q = prod[17:11];
      r = s - ({3'd0, q} * 10'd11);
      if (r >= 10'd11) begin
         r = r - 10'd11;
      end
      return r[3:0];
   endfunction

   // CPF (10*s mod 11, 10->0) and CNPJ (r<2 ? 0 : 11-r) reduce to the same map
   function automatic logic [3:0] check_digit(input logic [9:0] s);
      logic [3:0] r;
      r = mod_eleven(s);
      return (r < 4'd2) ? 4'd0 : (4'd11 - r);
   endfunction

endpackage

### rtl/tidv_front.sv
`timescale 1ns / 1ps

module tidv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_doc_kind,
   input  logic                req_last_char,
   input  logic                queue_full,
   output logic                push,
   output tidv_pkg::entry_type push_entry
);

   logic in_string_ff;
   logic in_string_in;
   logic is_digit;
   logic [7:0] offset;

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   assign is_digit = (req_char_code >= tidv_pkg::CharZero) &&
                     (req_char_code <= tidv_pkg::CharNine);
   assign offset = req_char_code - tidv_pkg::CharZero;

   always_comb begin
      push_entry.digit = offset[3:0];
      push_entry.is_digit = is_digit;
      push_entry.first = !in_string_ff;
      push_entry.last = req_last_char;
      push_entry.kind = req_doc_kind;
   end

   assign in_string_in = push ? !req_last_char : in_string_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
      end else begin
         in_string_ff <= in_string_in;
      end
   end

endmodule

### rtl/tidv_queue.sv
`timescale 1ns / 1ps

module tidv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tidv_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output tidv_pkg::entry_type head
);

   tidv_pkg::entry_type slots_ff [tidv_pkg::QueueDepth];
   logic [tidv_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tidv_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tidv_pkg::QueueCountWidth-1:0] count_ff, count_in;

   assign full = (count_ff == tidv_pkg::QueueCountWidth'(tidv_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue write while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

### rtl/tidv_back.sv
`timescale 1ns / 1ps

module tidv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  tidv_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_is_valid,
   output logic [1:0]          rsp_status
);

   // running per-string state
   logic       kind_ff, kind_in;
   logic [3:0] count_ff, count_in;
   logic [3:0] first_digit_ff, first_digit_in;
   logic       all_same_ff, all_same_in;
   logic [9:0] sum_one_ff, sum_one_in;
   logic [9:0] sum_two_ff, sum_two_in;
   logic [3:0] check_one_ff, check_one_in;
   logic [3:0] check_two_ff, check_two_in;

   // verdict stage
   logic       v_valid_ff;
   logic       v_kind_ff;
   logic [3:0] v_count_ff;
   logic       v_all_same_ff;
   logic [9:0] v_sum_one_ff;
   logic [9:0] v_sum_two_ff;
   logic [3:0] v_check_one_ff;
   logic [3:0] v_check_two_ff;

   logic       rsp_valid_ff;
   logic       rsp_is_valid_ff;
   tidv_pkg::status_type rsp_status_ff, status;

   logic       o_take, v_free, finish;
   logic [3:0] b_count, b_first_digit, b_check_one, b_check_two;
   logic       b_all_same;
   logic [9:0] b_sum_one, b_sum_two;
   logic [3:0] w_one, w_two;
   logic [3:0] pos_one, pos_two;
   logic [3:0] need;

   assign o_take = !rsp_valid_ff || !rsp_stall;
   assign v_free = !v_valid_ff || o_take;
   assign pop = !empty && (!head.last || v_free);
   assign finish = pop && head.last;

   always_comb begin
      kind_in = head.first ? head.kind : kind_ff;
      b_count = head.first ? 4'd0 : count_ff;
      b_first_digit = head.first ? 4'd0 : first_digit_ff;
      b_all_same = head.first ? 1'b1 : all_same_ff;
      b_sum_one = head.first ? 10'd0 : sum_one_ff;
      b_sum_two = head.first ? 10'd0 : sum_two_ff;
      b_check_one = head.first ? 4'd0 : check_one_ff;
      b_check_two = head.first ? 4'd0 : check_two_ff;

      w_one = tidv_pkg::weight_one(kind_in, b_count);
      w_two = tidv_pkg::weight_two(kind_in, b_count);
      pos_one = (kind_in == tidv_pkg::KIND_CNPJ) ? 4'd12 : 4'd9;
      pos_two = (kind_in == tidv_pkg::KIND_CNPJ) ? 4'd13 : 4'd10;

      count_in = b_count;
      first_digit_in = b_first_digit;
      all_same_in = b_all_same;
      sum_one_in = b_sum_one;
      sum_two_in = b_sum_two;
      check_one_in = b_check_one;
      check_two_in = b_check_two;
      if (head.is_digit) begin
         if (b_count == 4'd0) begin
            first_digit_in = head.digit;
         end else if (head.digit != b_first_digit) begin
            all_same_in = 1'b0;
         end
         sum_one_in = b_sum_one + ({6'd0, head.digit} * {6'd0, w_one});
         sum_two_in = b_sum_two + ({6'd0, head.digit} * {6'd0, w_two});
         if (b_count == pos_one) begin
            check_one_in = head.digit;
         end
         if (b_count == pos_two) begin
            check_two_in = head.digit;
         end
         if (b_count != tidv_pkg::CountMax) begin
            count_in = b_count + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= tidv_pkg::KIND_CPF;
         count_ff <= 4'd0;
         first_digit_ff <= 4'd0;
         all_same_ff <= 1'b1;
         sum_one_ff <= 10'd0;
         sum_two_ff <= 10'd0;
         check_one_ff <= 4'd0;
         check_two_ff <= 4'd0;
      end else if (pop) begin
         kind_ff <= kind_in;
         count_ff <= count_in;
         first_digit_ff <= first_digit_in;
         all_same_ff <= all_same_in;
         sum_one_ff <= sum_one_in;
         sum_two_ff <= sum_two_in;
         check_one_ff <= check_one_in;
         check_two_ff <= check_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (v_free) begin
         v_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         v_kind_ff <= kind_in;
         v_count_ff <= count_in;
         v_all_same_ff <= all_same_in;
         v_sum_one_ff <= sum_one_in;
         v_sum_two_ff <= sum_two_in;
         v_check_one_ff <= check_one_in;
         v_check_two_ff <= check_two_in;
      end
   end

   always_comb begin
      need = (v_kind_ff == tidv_pkg::KIND_CNPJ) ? tidv_pkg::CnpjLength : tidv_pkg::CpfLength;
      if (v_count_ff != need) begin
         status = tidv_pkg::STATUS_BAD_COUNT;
      end else if (v_all_same_ff) begin
         status = tidv_pkg::STATUS_ALL_SAME;
      end else if ((tidv_pkg::check_digit(v_sum_one_ff) != v_check_one_ff) ||
                   (tidv_pkg::check_digit(v_sum_two_ff) != v_check_two_ff)) begin
         status = tidv_pkg::STATUS_MISMATCH;
      end else begin
         status = tidv_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_take) begin
         rsp_valid_ff <= v_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_take && v_valid_ff) begin
         rsp_status_ff <= status;
         rsp_is_valid_ff <= (status == tidv_pkg::STATUS_OK);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_valid = rsp_is_valid_ff;
   assign rsp_status = rsp_status_ff;

   a_verdict_held: assert property (@(posedge clock) disable iff (reset)
      (v_valid_ff && !v_free) |=> v_valid_ff)
      else $error("pending verdict dropped while output stalled");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (finish) |-> v_free)
      else $error("string closed with verdict stage busy");

endmodule

### rtl/tax_id_mod11_check_validator_core.sv
`timescale 1ns / 1ps
// channel | direction | ports                                          | transfer
// req     | in        | req_char_code[7:0] req_doc_kind req_last_char  | req_valid & !req_stall
// rsp     | out       | rsp_is_valid rsp_status[1:0]                   | rsp_valid & !rsp_stall
//
// One character per cycle sustained unless rsp_stall backs up; the per-character accumulate
// is a single back stage. rsp_valid rises after the last character passes the queue slot,
// then accumulate into the verdict register, then status into the output register.
// Reset: synchronous, active high; clears queue, string tracking and valid flags.
// req_stall rises only when the 4-entry queue is full; rsp_stall backs up through the
// verdict and output registers, then the queue.

module tax_id_mod11_check_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_doc_kind,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_valid,
   output logic [1:0] rsp_status
);

   logic                push, pop, full, empty;
   tidv_pkg::entry_type push_entry, head;

   tidv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_doc_kind  (req_doc_kind),
      .req_last_char (req_last_char),
      .queue_full    (full),
      .push          (push),
      .push_entry    (push_entry)
   );

   tidv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   tidv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_valid (rsp_is_valid),
      .rsp_status   (rsp_status)
   );

endmodule
